// ===== src/quoted_escaped_tokenizer_macros.svh =====
// assertion macros for the quoted escaped tokenizer
// no dependencies; included by modules that carry assertions
`ifndef QUOTED_ESCAPED_TOKENIZER_MACROS_SVH
`define QUOTED_ESCAPED_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define QET_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define QET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/qet_pkg.sv =====
// shared types and constants for the quoted escaped tokenizer
// no dependencies
`timescale 1ns / 1ps

package qet_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int RES_SLOTS = 3;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELIM_BYTES = 3'd0,
        CFG_DELIM_COUNT = 3'd1,
        CFG_TOKEN_LIMIT = 3'd2,
        CFG_QUOTES_EN   = 3'd3,
        CFG_ESCAPES_EN  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       valid;
        logic       tok_end;
        logic       str_done;
    } result_t;

endpackage

// ===== src/quoted_escaped_tokenizer.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_byte, string_last
// out     | out | out_valid/out_ready | out_byte, byte_valid, token_end, string_done
// cfg     | in  | cfg_we              | cfg_index, cfg_data
// one input beat per cycle while each byte yields at most one result and out_ready is high
// a byte yielding k results (k up to 3) holds the output bundle until all k are taken;
// in_ready returns when the last result of the bundle is being taken
// results are registered into the bundle when the byte is accepted; output stalls hold the bundle
// reset: registers take their power-up values, no clearing pass
// depends on qet_pkg and quoted_escaped_tokenizer_macros.svh
`timescale 1ns / 1ps

module quoted_escaped_tokenizer #(
    parameter int MAX_DELIMITERS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [7:0]                   in_byte,
    input  logic                         string_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [7:0]                   out_byte,
    output logic                         byte_valid,
    output logic                         token_end,
    output logic                         string_done,
    input  logic                         cfg_we,
    input  logic [qet_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                  cfg_data
);
    import qet_pkg::*;

    `include "quoted_escaped_tokenizer_macros.svh"

    localparam int NUM_DELIMS = (MAX_DELIMITERS < 4) ? MAX_DELIMITERS : 4;

    // configuration
    logic [31:0] delim_bytes_reg;
    logic [2:0]  delim_count_reg;
    logic [7:0]  token_limit_reg;
    logic        quotes_en_reg;
    logic        escapes_en_reg;

    // string state
    logic       in_quote_reg, in_quote_next;
    logic       bs_pending_reg, bs_pending_next;
    logic       skipping_reg, skipping_next;
    logic       raw_rest_reg, raw_rest_next;
    logic [7:0] tokens_reg, tokens_next;
    logic [7:0] held_byte_reg, held_byte_next;
    logic       held_valid_reg, held_valid_next;

    // result bundle
    result_t    slot_reg [RES_SLOTS];
    result_t    slot_next [RES_SLOTS];
    logic [1:0] count_reg;
    logic [1:0] rd_reg;
    logic [1:0] n_next;

    logic in_fire, out_fire;
    logic delim_hit;
    logic limit_hit;
    logic do_tok, app_bs, app_c, do_end, tog_q, bp_set, bp_clr;
    result_t out_res;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);

    assign out_res     = slot_reg[rd_reg];
    assign out_valid   = (count_reg != 2'd0);
    assign out_byte    = out_res.ch;
    assign byte_valid  = out_res.valid;
    assign token_end   = out_res.tok_end;
    assign string_done = out_res.str_done;

    always_comb
    begin
        delim_hit = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (i < NUM_DELIMS && delim_count_reg > 3'(i)
                && delim_bytes_reg[8*i +: 8] == in_byte)
                delim_hit = 1'b1;
        end
    end

    assign limit_hit = (token_limit_reg != 8'd0) && (tokens_reg >= token_limit_reg - 8'd1);

    // decide the actions for this byte
    always_comb
    begin
        do_tok        = 1'b0;
        app_bs        = 1'b0;
        app_c         = 1'b0;
        do_end        = 1'b0;
        tog_q         = 1'b0;
        bp_set        = 1'b0;
        bp_clr        = 1'b0;
        skipping_next = skipping_reg;
        raw_rest_next = raw_rest_reg;
        priority if (raw_rest_reg)
        begin
            app_c = 1'b1;
        end
        else if (skipping_reg)
        begin
            if (!delim_hit)
            begin
                skipping_next = 1'b0;
                if (limit_hit)
                begin
                    raw_rest_next = 1'b1;
                    app_c         = 1'b1;
                end
                else
                begin
                    do_tok = 1'b1;
                end
            end
        end
        else
        begin
            do_tok = 1'b1;
        end

        if (do_tok)
        begin
            priority if (delim_hit && bs_pending_reg && escapes_en_reg)
            begin
                app_c  = 1'b1;
                bp_clr = 1'b1;
            end
            else if (delim_hit && !in_quote_reg)
            begin
                do_end = 1'b1;
            end
            else if (!quotes_en_reg)
            begin
                app_c = 1'b1;
            end
            else if (in_byte == CH_BACKSLASH || in_byte == CH_QUOTE)
            begin
                if (bs_pending_reg)
                begin
                    app_c  = 1'b1;
                    bp_clr = 1'b1;
                end
                else if (in_byte == CH_BACKSLASH)
                begin
                    bp_set = 1'b1;
                end
                else
                begin
                    do_end = 1'b1;
                    tog_q  = 1'b1;
                end
            end
            else
            begin
                app_bs = bs_pending_reg && !escapes_en_reg;
                bp_clr = bs_pending_reg;
                app_c  = 1'b1;
            end
        end
    end

    // carry out the actions and build the result bundle
    always_comb
    begin
        for (int k = 0; k < RES_SLOTS; k++)
            slot_next[k] = slot_reg[k];
        n_next          = 2'd0;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        tokens_next     = tokens_reg;
        in_quote_next   = in_quote_reg;
        bs_pending_next = bs_pending_reg;

        if (app_bs)
        begin
            if (held_valid_next)
            begin
                slot_next[n_next] = '{ch: held_byte_next, valid: 1'b1,
                                      tok_end: 1'b0, str_done: 1'b0};
                n_next = n_next + 2'd1;
            end
            held_byte_next  = CH_BACKSLASH;
            held_valid_next = 1'b1;
        end
        if (app_c)
        begin
            if (held_valid_next)
            begin
                slot_next[n_next] = '{ch: held_byte_next, valid: 1'b1,
                                      tok_end: 1'b0, str_done: 1'b0};
                n_next = n_next + 2'd1;
            end
            held_byte_next  = in_byte;
            held_valid_next = 1'b1;
        end
        if (bp_set)
            bs_pending_next = 1'b1;
        if (bp_clr)
            bs_pending_next = 1'b0;
        if (do_end)
        begin
            if (held_valid_next)
            begin
                slot_next[n_next] = '{ch: held_byte_next, valid: 1'b1,
                                      tok_end: 1'b1, str_done: 1'b0};
                n_next = n_next + 2'd1;
                if (tokens_next != 8'hFF)
                    tokens_next = tokens_next + 8'd1;
                held_valid_next = 1'b0;
                held_byte_next  = 8'd0;
            end
            bs_pending_next = 1'b0;
        end
        if (tog_q)
            in_quote_next = !in_quote_reg;

        if (string_last)
        begin
            slot_next[n_next] = '{ch: held_valid_next ? held_byte_next : 8'd0,
                                  valid: held_valid_next, tok_end: held_valid_next,
                                  str_done: 1'b1};
            n_next = n_next + 2'd1;
            in_quote_next   = 1'b0;
            bs_pending_next = 1'b0;
            tokens_next     = 8'd0;
            held_byte_next  = 8'd0;
            held_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_bytes_reg <= 32'd32;
            delim_count_reg <= 3'd1;
            token_limit_reg <= 8'd0;
            quotes_en_reg   <= 1'b0;
            escapes_en_reg  <= 1'b0;
            in_quote_reg    <= 1'b0;
            bs_pending_reg  <= 1'b0;
            skipping_reg    <= 1'b1;
            raw_rest_reg    <= 1'b0;
            tokens_reg      <= 8'd0;
            held_byte_reg   <= 8'd0;
            held_valid_reg  <= 1'b0;
            count_reg       <= 2'd0;
            rd_reg          <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DELIM_BYTES: delim_bytes_reg <= cfg_data;
                    CFG_DELIM_COUNT: delim_count_reg <= cfg_data[2:0];
                    CFG_TOKEN_LIMIT: token_limit_reg <= cfg_data[7:0];
                    CFG_QUOTES_EN:   quotes_en_reg   <= cfg_data[0];
                    CFG_ESCAPES_EN:  escapes_en_reg  <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (in_fire)
            begin
                in_quote_reg   <= in_quote_next;
                bs_pending_reg <= bs_pending_next;
                skipping_reg   <= string_last ? 1'b1 : (do_end ? 1'b1 : skipping_next);
                raw_rest_reg   <= string_last ? 1'b0 : raw_rest_next;
                tokens_reg     <= tokens_next;
                held_byte_reg  <= held_byte_next;
                held_valid_reg <= held_valid_next;
                count_reg      <= n_next;
                rd_reg         <= 2'd0;
            end
            else if (out_fire)
            begin
                count_reg <= count_reg - 2'd1;
                rd_reg    <= rd_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int k = 0; k < RES_SLOTS; k++)
                slot_reg[k] <= slot_next[k];
        end
    end

    `QET_ASSERT_NEXT(a_last_gives_beat, in_fire && string_last, out_valid, "no beat after last byte")
    `QET_ASSERT_NEXT(a_last_clears, in_fire && string_last, skipping_reg && !held_valid_reg && tokens_reg == 8'd0 && !raw_rest_reg, "string state not cleared")
    `QET_ASSERT_NOW(a_done_is_final, out_valid && string_done, count_reg == 2'd1, "string_done beat is not the last of its bundle")
    `QET_ASSERT_NOW(a_marker_only, out_valid && !byte_valid, string_done && !token_end, "empty beat without string_done")
    `QET_ASSERT_NOW(a_held_not_skipping, held_valid_reg, !skipping_reg, "held byte while skipping delimiters")

endmodule

// ===== sim/tb_quoted_escaped_tokenizer.sv =====
// self-checking testbench for quoted_escaped_tokenizer: directed strings, then random strings
// under several register settings, with random stalls on both channels
// depends on qet_pkg and the quoted_escaped_tokenizer rtl
`timescale 1ns / 1ps

module tb_quoted_escaped_tokenizer;
    import qet_pkg::*;

    localparam int MAX_DELIMS    = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int PHASES        = 8;
    localparam int PHASE_BEATS   = 12;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           in_byte;
    logic                 string_last;
    logic                 out_valid;
    logic                 out_ready;
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 token_end;
    logic                 string_done;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // shadow registers and tokenizer state
    logic [31:0] cfg_delims;
    logic [2:0]  cfg_count;
    logic [7:0]  cfg_limit;
    logic        cfg_quotes;
    logic        cfg_escapes;

    logic        in_span;
    logic        bs_pending;
    logic        skipping;
    logic        raw_rest;
    logic [7:0]  tok_count;
    logic [7:0]  held_char;
    logic        held_valid;

    result_t     token_beats_q[$];

    int fail_count;
    int beats_in;
    int beats_out;
    int settings_used;
    int cycle_count;
    bit no_gaps;
    bit hold_request;

    quoted_escaped_tokenizer #(
        .MAX_DELIMITERS(MAX_DELIMS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .string_last(string_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .token_end  (token_end),
        .string_done(string_done),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d result beats outstanding", $time,
                     token_beats_q.size());
            $display("tb_quoted_escaped_tokenizer: FAIL");
            $finish;
        end
    end

    // ---------------- token predictor ----------------

    function automatic void clear_string_state();
        in_span    = 1'b0;
        bs_pending = 1'b0;
        skipping   = 1'b1;
        raw_rest   = 1'b0;
        tok_count  = 8'd0;
        held_char  = 8'd0;
        held_valid = 1'b0;
    endfunction

    function automatic void reset_shadow();
        cfg_delims  = 32'h0000_0020;
        cfg_count   = 3'd1;
        cfg_limit   = 8'd0;
        cfg_quotes  = 1'b0;
        cfg_escapes = 1'b0;
        clear_string_state();
    endfunction

    function automatic logic is_delim_char(logic [7:0] c);
        int n;
        n = cfg_count;
        if (n > MAX_DELIMS)
            n = MAX_DELIMS;
        if (n > 4)
            n = 4;
        for (int i = 0; i < n; i++)
            if (cfg_delims[8*i +: 8] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_beat(logic [7:0] ch, logic v, logic e, logic d);
        result_t r;
        r.ch       = ch;
        r.valid    = v;
        r.tok_end  = e;
        r.str_done = d;
        token_beats_q = {token_beats_q, r};
    endfunction

    function automatic void hold_char(logic [7:0] c);
        if (held_valid)
            push_beat(held_char, 1'b1, 1'b0, 1'b0);
        held_char  = c;
        held_valid = 1'b1;
    endfunction

    function automatic void close_token();
        if (held_valid)
        begin
            push_beat(held_char, 1'b1, 1'b1, 1'b0);
            if (tok_count != 8'hFF)
                tok_count++;
            held_valid = 1'b0;
            held_char  = 8'd0;
        end
        bs_pending = 1'b0;
        skipping   = 1'b1;
    endfunction

    function automatic void token_char(logic [7:0] c);
        logic delim;
        delim = is_delim_char(c);
        if (delim && bs_pending && cfg_escapes)
        begin
            hold_char(c);
            bs_pending = 1'b0;
        end
        else if (delim && !in_span)
            close_token();
        else if (!cfg_quotes)
            hold_char(c);
        else if (c == CH_BACKSLASH || c == CH_QUOTE)
        begin
            if (bs_pending)
            begin
                hold_char(c);
                bs_pending = 1'b0;
            end
            else if (c == CH_BACKSLASH)
                bs_pending = 1'b1;
            else
            begin
                close_token();
                in_span = !in_span;
            end
        end
        else
        begin
            // lone backslash kept only when escapes are off
            if (bs_pending)
            begin
                if (!cfg_escapes)
                    hold_char(CH_BACKSLASH);
                bs_pending = 1'b0;
            end
            hold_char(c);
        end
    endfunction

    function automatic void tokenize_char(logic [7:0] c, logic last);
        if (raw_rest)
            hold_char(c);
        else if (skipping)
        begin
            if (!is_delim_char(c))
            begin
                skipping = 1'b0;
                if (cfg_limit != 0 && tok_count >= cfg_limit - 1)
                begin
                    raw_rest = 1'b1;
                    hold_char(c);
                end
                else
                    token_char(c);
            end
        end
        else
            token_char(c);

        if (last)
        begin
            if (held_valid)
                push_beat(held_char, 1'b1, 1'b1, 1'b1);
            else
                push_beat(8'd0, 1'b0, 1'b0, 1'b1);
            clear_string_state();
        end
    endfunction

    // ---------------- result checking ----------------

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (token_beats_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got byte %0h v%0b e%0b d%0b",
                         $time, out_byte, byte_valid, token_end, string_done);
                fail_count++;
            end
            else
            begin
                want = token_beats_q.pop_front();
                check_field("out_byte", want.ch, out_byte);
                check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
                check_field("token_end", 8'(want.tok_end), 8'(token_end));
                check_field("string_done", 8'(want.str_done), 8'(string_done));
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    // receiver side, long hold counted here
    initial
    begin : out_ready_driver
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic send_char(logic [7:0] c, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_byte     <= c;
        string_last <= last;
        do
            @(posedge clk);
        while (!in_ready);
        beats_in++;
        tokenize_char(c, last);
    endtask

    task automatic send_text(string s, bit terminate);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], terminate && (i == s.len() - 1));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (token_beats_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DELIM_BYTES: cfg_delims  = val;
            CFG_DELIM_COUNT: cfg_count   = val[2:0];
            CFG_TOKEN_LIMIT: cfg_limit   = val[7:0];
            CFG_QUOTES_EN:   cfg_quotes  = val[0];
            CFG_ESCAPES_EN:  cfg_escapes = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [31:0] delims, logic [2:0] count, logic [7:0] limit,
                              logic quotes, logic escapes);
        wait_idle();
        write_reg(CFG_DELIM_BYTES, delims);
        write_reg(CFG_DELIM_COUNT, {29'd0, count});
        write_reg(CFG_TOKEN_LIMIT, {24'd0, limit});
        write_reg(CFG_QUOTES_EN, {31'd0, quotes});
        write_reg(CFG_ESCAPES_EN, {31'd0, escapes});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_delim();
        case ($urandom_range(0, 5))
            0:       return 8'h20;
            1:       return 8'h2C;
            2:       return CH_QUOTE;
            3:       return CH_BACKSLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20)
            return cfg_delims[8*$urandom_range(0, 3) +: 8];
        if (r < 30)
            return CH_QUOTE;
        if (r < 40)
            return CH_BACKSLASH;
        if (r < 85)
            return 8'h61 + 8'($urandom_range(0, 7));
        return 8'($urandom_range(0, 255));
    endfunction

    // ---------------- tests ----------------

    task automatic test_plain_split();
        // delimiters of both kinds, byte extremes, end-of-string marker
        set_config(32'h0000_2C20, 3'd2, 8'd0, 1'b0, 1'b0);
        send_text(" a,", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h20, 1'b1);
    endtask

    task automatic test_quote_escape();
        // escaped quote and backslash, kept lone backslash, skip inside span,
        // backslash pending at string end
        set_config(32'h0000_0020, 3'd1, 8'd0, 1'b1, 1'b0);
        send_text("\\\"\\\\\\d\"  q\"z\\", 1'b1);
    endtask

    task automatic test_special_delimiters();
        // quote and backslash as delimiters, count above four
        set_config(32'h3A5C_2220, 3'd6, 8'd0, 1'b1, 1'b0);
        send_text("a\"b\\c:d", 1'b1);
        // raw tail after the token limit
        set_config(32'h0000_0020, 3'd1, 8'd2, 1'b0, 1'b0);
        send_text("p q r", 1'b1);
    endtask

    task automatic test_midstring_update();
        // quotes dropped with a backslash pending, escapes on from the next beat
        set_config(32'h0000_0020, 3'd1, 8'd0, 1'b1, 1'b0);
        send_text("a\\", 1'b0);
        set_config(32'h0000_0020, 3'd1, 8'd0, 1'b0, 1'b1);
        send_text(" b", 1'b0);
        set_config(32'h0000_0020, 3'd1, 8'd0, 1'b1, 1'b1);
        send_text("\\c", 1'b1);
    endtask

    task automatic test_output_stall();
        set_config(32'h0000_0020, 3'd1, 8'd0, 1'b0, 1'b0);
        no_gaps      = 1'b1;
        hold_request = 1'b1;
        for (int i = 0; i < 40; i++)
            send_char((i % 5 == 4) ? 8'h20 : 8'h61 + 8'(i % 26), i % 10 == 9);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_strings();
        logic [31:0] delims;
        int          sent;
        int          len;
        for (int p = 0; p < PHASES; p++)
        begin
            for (int k = 0; k < 4; k++)
                delims[8*k +: 8] = pick_delim();
            case (p)
                0: set_config(32'h0000_0000, 3'd0, 8'd0, 1'b0, 1'b0);
                1: set_config(32'hFFFF_FFFF, 3'd7, 8'd255, 1'b1, 1'b1);
                2: set_config(delims, 3'($urandom_range(1, 4)), 8'd1, 1'b1, 1'b0);
                default:
                    set_config(delims, 3'($urandom_range(0, 7)),
                               ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                           : 8'($urandom_range(0, 3)),
                               $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            endcase
            no_gaps = (p == 6);
            sent = 0;
            while (sent < PHASE_BEATS)
            begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    send_char(random_char(), i == len - 1);
                sent += len;
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        in_valid    <= 1'b0;
        in_byte     <= 8'd0;
        string_last <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_DELIM_BYTES;
        cfg_data    <= 32'd0;
        rst_n       <= 1'b0;
        reset_shadow();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_split();
        test_quote_escape();
        test_special_delimiters();
        test_midstring_update();
        test_output_stall();
        test_random_strings();
        wait_idle();

        if (token_beats_q.size() != 0)
        begin
            $display("%0t: %0d result beats never arrived", $time, token_beats_q.size());
            fail_count += token_beats_q.size();
        end
        $display("sent %0d input beats, checked %0d result beats under %0d register settings",
                 beats_in, beats_out, settings_used);
        $display("covered quote spans, escapes, token limits, raw tails and output stalls");
        if (fail_count == 0)
            $display("tb_quoted_escaped_tokenizer: PASS");
        else
            $display("tb_quoted_escaped_tokenizer: FAIL");
        $finish;
    end

endmodule
